// ===== rtl/wcp_pkg.sv =====
// Shared types, constants and helper functions of the WAV chunk parser.
package wcp_pkg;

  // One input beat: a file byte with its framing marks.
  typedef struct packed {
    logic [7:0] file_byte;
    logic       first_byte;
    logic       end_of_file;
  } wcp_in_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  audio_byte;
    logic        frame_end;
    logic        last_audio;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] frame_bytes;
  } wcp_out_t;

  // Status codes carried in the result.
  localparam logic [2:0] ST_HEADER     = 3'd0;
  localparam logic [2:0] ST_AUDIO      = 3'd1;
  localparam logic [2:0] ST_DONE       = 3'd2;
  localparam logic [2:0] ST_BAD_RIFF   = 3'd3;
  localparam logic [2:0] ST_BAD_FORMAT = 3'd4;
  localparam logic [2:0] ST_DATA_EARLY = 3'd5;
  localparam logic [2:0] ST_MISSING    = 3'd6;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_HEADER,
    PH_CHDR,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_DONE,
    PH_ERR_RIFF,
    PH_ERR_FMT,
    PH_ERR_ORD,
    PH_ERR_MISS
  } phase_t;

  // Chunk IDs as they read in file order, first byte in the top lane.
  localparam logic [31:0] ID_FMT  = 32'h666D_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;

  localparam logic [4:0]  HDR_LEN         = 5'd12;
  localparam logic [2:0]  CHDR_LAST       = 3'd7;
  localparam logic [4:0]  FMT_STORE       = 5'd18;
  localparam logic [15:0] TAG_PCM         = 16'd1;
  localparam logic [15:0] BITS_PCM16      = 16'd16;
  localparam logic [31:0] SKIP_ALIGN_MASK = ~32'd1;

  // Complete parser state.
  typedef struct packed {
    phase_t      phase;
    logic [4:0]  idx;
    logic [31:0] chunk_id;
    logic [31:0] chunk_size;
    logic [31:0] remaining;
    logic        have_format;
    logic [15:0] format_tag;
    logic [15:0] channels_seen;
    logic [31:0] rate_seen;
    logic [15:0] align_seen;
    logic [15:0] bits_seen;
    logic [15:0] frame_position;
  } parser_state_t;

  localparam parser_state_t PARSER_RESET = '{
    phase:          PH_HEADER,
    idx:            5'd0,
    chunk_id:       32'd0,
    chunk_size:     32'd0,
    remaining:      32'd0,
    have_format:    1'b0,
    format_tag:     16'd0,
    channels_seen:  16'd0,
    rate_seen:      32'd0,
    align_seen:     16'd0,
    bits_seen:      16'd0,
    frame_position: 16'd0
  };

  // Expected byte of the RIFF....WAVE header at a given offset.
  function automatic logic [7:0] riff_hdr_byte(input logic [3:0] k);
    logic [7:0] b;
    case (k)
      4'd0:    b = 8'h52;  // R
      4'd1:    b = 8'h49;  // I
      4'd2:    b = 8'h46;  // F
      4'd3:    b = 8'h46;  // F
      4'd8:    b = 8'h57;  // W
      4'd9:    b = 8'h41;  // A
      4'd10:   b = 8'h56;  // V
      4'd11:   b = 8'h45;  // E
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // The size field of the RIFF header is not checked.
  function automatic logic riff_hdr_checked(input logic [4:0] k);
    return (k < HDR_LEN) && ((k < 5'd4) || (k >= 5'd8));
  endfunction

  // Number of fmt bytes that are kept: min(size, 18).
  function automatic logic [4:0] fmt_stored(input logic [31:0] size);
    return (size < {27'd0, FMT_STORE}) ? size[4:0] : FMT_STORE;
  endfunction

endpackage

// ===== rtl/wcp_parser.sv =====
// Parser state register and the one-byte step of the RIFF/WAVE chunk walker.
module wcp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  wcp_pkg::wcp_in_t  item,
  output wcp_pkg::wcp_out_t result
);
  import wcp_pkg::*;

  parser_state_t state;
  parser_state_t state_next;
  parser_state_t cur;
  logic          audio;
  logic          fend;
  logic          last;
  logic          do_finish;
  logic [2:0]    k;
  logic [31:0]   skip_len;
  logic [31:0]   rest;

  // State register; advances once per processed beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PARSER_RESET;
    end else if (step) begin
      state <= state_next;
    end
  end

  // Next state and result for the byte being processed.
  always_comb begin
    cur        = item.first_byte ? PARSER_RESET : state;
    state_next = cur;
    audio      = 1'b0;
    fend       = 1'b0;
    last       = 1'b0;
    do_finish  = 1'b0;
    k          = cur.idx[2:0];
    skip_len   = 32'd0;
    rest       = 32'd0;

    unique case (cur.phase)
      PH_HEADER: begin
        if (riff_hdr_checked(cur.idx) && riff_hdr_byte(cur.idx[3:0]) != item.file_byte) begin
          state_next.phase = PH_ERR_RIFF;
        end else if (cur.idx + 5'd1 >= HDR_LEN) begin
          state_next.idx   = 5'd0;
          state_next.phase = PH_CHDR;
        end else begin
          state_next.idx = cur.idx + 5'd1;
        end
      end

      PH_CHDR: begin
        // Four ID bytes shift in, then four little-endian size bytes.
        if (!k[2]) begin
          state_next.chunk_id = {cur.chunk_id[23:0], item.file_byte};
          if (k == 3'd0) begin
            state_next.chunk_size = 32'd0;
          end
        end else begin
          state_next.chunk_size = cur.chunk_size | ({24'd0, item.file_byte} << {k[1:0], 3'b000});
        end
        state_next.idx = {2'b00, k} + 5'd1;
        if (k == CHDR_LAST) begin
          // Chunk header complete: pick how to handle the body.
          state_next.idx = 5'd0;
          if (state_next.chunk_id == ID_FMT) begin
            if (fmt_stored(state_next.chunk_size) == 5'd0) begin
              do_finish = 1'b1;
            end else begin
              state_next.phase = PH_FMT;
            end
          end else if (state_next.chunk_id == ID_DATA) begin
            if (!cur.have_format) begin
              state_next.phase = PH_ERR_ORD;
            end else begin
              state_next.remaining      = state_next.chunk_size;
              state_next.frame_position = 16'd0;
              state_next.phase = (state_next.chunk_size < {16'd0, cur.align_seen}) ?
                                 PH_DONE : PH_DATA;
            end
          end else begin
            skip_len = (state_next.chunk_size + 32'd1) & SKIP_ALIGN_MASK;
            if (skip_len == 32'd0) begin
              state_next.phase = PH_CHDR;
            end else begin
              state_next.remaining = skip_len;
              state_next.phase     = PH_SKIP;
            end
          end
        end
      end

      PH_FMT: begin
        // Store the byte into its format field by offset.
        case (cur.idx)
          5'd0:    state_next.format_tag[7:0]     = item.file_byte;
          5'd1:    state_next.format_tag[15:8]    = item.file_byte;
          5'd2:    state_next.channels_seen[7:0]  = item.file_byte;
          5'd3:    state_next.channels_seen[15:8] = item.file_byte;
          5'd4:    state_next.rate_seen[7:0]      = item.file_byte;
          5'd5:    state_next.rate_seen[15:8]     = item.file_byte;
          5'd6:    state_next.rate_seen[23:16]    = item.file_byte;
          5'd7:    state_next.rate_seen[31:24]    = item.file_byte;
          5'd12:   state_next.align_seen[7:0]     = item.file_byte;
          5'd13:   state_next.align_seen[15:8]    = item.file_byte;
          5'd14:   state_next.bits_seen[7:0]      = item.file_byte;
          5'd15:   state_next.bits_seen[15:8]     = item.file_byte;
          default: ;
        endcase
        state_next.idx = cur.idx + 5'd1;
        if (state_next.idx >= fmt_stored(cur.chunk_size)) begin
          do_finish = 1'b1;
        end
      end

      PH_SKIP: begin
        if (cur.remaining != 32'd0) begin
          state_next.remaining = cur.remaining - 32'd1;
        end
        if (state_next.remaining == 32'd0) begin
          state_next.idx   = 5'd0;
          state_next.phase = PH_CHDR;
        end
      end

      PH_DATA: begin
        audio = 1'b1;
        if (cur.remaining != 32'd0) begin
          state_next.remaining = cur.remaining - 32'd1;
        end
        state_next.frame_position = cur.frame_position + 16'd1;
        if (state_next.frame_position >= cur.align_seen) begin
          fend = 1'b1;
          state_next.frame_position = 16'd0;
          if (state_next.remaining < {16'd0, cur.align_seen}) begin
            last = 1'b1;
            state_next.phase = PH_DONE;
          end
        end
      end

      default: ;
    endcase

    // Format check once the kept fmt bytes are in.
    if (do_finish) begin
      if (state_next.format_tag != TAG_PCM || state_next.bits_seen != BITS_PCM16 ||
          state_next.rate_seen == 32'd0 || state_next.align_seen == 16'd0) begin
        state_next.phase = PH_ERR_FMT;
      end else begin
        state_next.have_format = 1'b1;
        state_next.idx         = 5'd0;
        rest = state_next.chunk_size - {27'd0, fmt_stored(state_next.chunk_size)};
        if (rest == 32'd0) begin
          state_next.phase = PH_CHDR;
        end else begin
          state_next.remaining = rest;
          state_next.phase     = PH_SKIP;
        end
      end
    end

    // The file ending early is an error.
    if (item.end_of_file) begin
      if (state_next.phase == PH_HEADER) begin
        state_next.phase = PH_ERR_RIFF;
      end else if (state_next.phase == PH_CHDR || state_next.phase == PH_FMT ||
                   state_next.phase == PH_SKIP) begin
        state_next.phase = PH_ERR_MISS;
      end
    end

    // Result fields.
    if (audio) begin
      result.status = ST_AUDIO;
    end else begin
      unique case (state_next.phase)
        PH_DONE:     result.status = ST_DONE;
        PH_ERR_RIFF: result.status = ST_BAD_RIFF;
        PH_ERR_FMT:  result.status = ST_BAD_FORMAT;
        PH_ERR_ORD:  result.status = ST_DATA_EARLY;
        PH_ERR_MISS: result.status = ST_MISSING;
        default:     result.status = ST_HEADER;
      endcase
    end
    result.audio_byte    = audio ? item.file_byte : 8'd0;
    result.frame_end     = fend;
    result.last_audio    = last;
    result.channel_count = state_next.have_format ? state_next.channels_seen : 16'd0;
    result.sample_rate   = state_next.have_format ? state_next.rate_seen : 32'd0;
    result.frame_bytes   = state_next.have_format ? state_next.align_seen : 16'd0;
  end

endmodule

// ===== rtl/wav_chunk_parser_top.sv =====
// Top level of the WAV chunk parser: input register, parser step, result register.
// An accepted byte waits in the input register; the parser step loads its result beat into
//   the result register once that register is free or being drained.
// Throughput: one byte per cycle unless stalled, set by the single parser step in between.
// Reset: rst is synchronous and active high; it empties both registers and returns
//   the parser to the header phase with all stored fmt fields cleared.
module wav_chunk_parser_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  wcp_pkg::wcp_in_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output wcp_pkg::wcp_out_t result
);
  import wcp_pkg::*;

  wcp_in_t  item_hold;
  logic     item_hold_valid;
  wcp_out_t step_result;
  logic     advance;

  // A held byte moves on when the result register is free or being drained.
  assign advance    = item_hold_valid && (!result_valid || result_ready);
  assign item_ready = !item_hold_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_hold_valid <= 1'b0;
    end else if (item_ready) begin
      item_hold_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      item_hold <= item;
    end
  end

  wcp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item_hold),
    .result (step_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result <= step_result;
    end
  end

endmodule

// ===== rtl/wcp_checker.sv =====
// Port-level checks of the WAV chunk parser and their binding to the top level.
module wcp_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input wcp_pkg::wcp_out_t result
);
  import wcp_pkg::*;

  // A stalled result beat holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // Audio byte and frame marks appear only on audio beats.
  a_audio_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_AUDIO |->
      result.audio_byte == 8'd0 && !result.frame_end && !result.last_audio)
    else $error("audio fields set outside an audio beat");

  // The last frame mark comes only with a frame end.
  a_last_is_frame_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_audio |-> result.frame_end)
    else $error("last_audio without frame_end");

  // Audio flows only under an accepted format with nonzero rate and frame size.
  a_audio_has_format: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_AUDIO |->
      result.frame_bytes != 16'd0 && result.sample_rate != 32'd0)
    else $error("audio beat without an accepted format");

endmodule

bind wav_chunk_parser_top wcp_checker u_wcp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the byte-serial WAV chunk parser.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wcp_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int QUIET_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 80;
  localparam int NUM_SHAPES   = 10;

  localparam logic [31:0] TAG_RIFF        = "RIFF";
  localparam logic [31:0] TAG_WAVE        = "WAVE";
  localparam logic [95:0] RIFF_WAVE_MAGIC = {"RIFF", 32'h0, "WAVE"};

  // Kinds of generated files; most are well formed, the rest are broken on purpose.
  typedef enum int {
    WF_CLEAN,
    WF_TWO_FMT,
    WF_SHORT_DATA,
    WF_CUT_IN_DATA,
    WF_DATA_FIRST,
    WF_NO_DATA,
    WF_WRAP_SIZE,
    WF_BAD_FMT,
    WF_CUT_HEADER,
    WF_NOISE
  } wav_shape_t;

  // One row of the directed part; typed rows carry their own status, the rest use the model.
  typedef struct packed {
    logic [7:0] b;
    logic       sof;
    logic       eof;
    logic       typed;
    logic [2:0] status;
  } dir_row_t;

  dir_row_t directed_rows [25] = '{
    '{8'h52, 1'b1, 1'b0, 1'b1, ST_HEADER},      // first byte after reset
    '{8'hFF, 1'b0, 1'b0, 1'b1, ST_BAD_RIFF},    // header mismatch
    '{8'h00, 1'b1, 1'b1, 1'b1, ST_BAD_RIFF},    // restart, mismatch and file end at once
    '{8'h52, 1'b1, 1'b0, 1'b0, ST_HEADER},
    '{8'h49, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'h46, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'h46, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_HEADER},      // unchecked RIFF size bytes
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'h57, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'h41, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'h56, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'h45, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'h66, 1'b0, 1'b0, 1'b0, ST_HEADER},      // "fmt " with size zero
    '{8'h6D, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'h74, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'h20, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_HEADER},
    '{8'h00, 1'b0, 1'b0, 1'b1, ST_BAD_FORMAT},  // empty fmt fails on cleared fields
    '{8'hFF, 1'b0, 1'b0, 1'b1, ST_BAD_FORMAT},  // error is sticky
    '{8'h57, 1'b1, 1'b1, 1'b1, ST_BAD_RIFF}     // restart on a wrong byte that ends the file
  };

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_ready;
  wcp_in_t  item_beat = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  wcp_out_t result_beat;

  wcp_out_t   pending_results[$];
  logic [7:0] file_q[$];
  int         bad_beats = 0;
  int         send_gap_pct = 0;
  int         recv_stall_pct = 0;
  logic       hold_asked = 1'b0;
  logic       hold_done = 1'b0;
  int         hold_left = 0;

  // Parser state as the testbench tracks it.
  phase_t      wp_phase;
  logic [4:0]  wp_index;
  logic [31:0] wp_id;
  logic [31:0] wp_size;
  logic [32:0] wp_left;
  logic        wp_have_fmt;
  logic [15:0] wp_tag;
  logic [15:0] wp_chans;
  logic [31:0] wp_rate;
  logic [15:0] wp_align;
  logic [15:0] wp_bits;
  logic [15:0] wp_frame_pos;

  always #1 clk = ~clk;

  wav_chunk_parser_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_beat)
  );

  task automatic parser_clear();
    wp_phase     = PH_HEADER;
    wp_index     = '0;
    wp_id        = '0;
    wp_size      = '0;
    wp_left      = '0;
    wp_have_fmt  = 1'b0;
    wp_tag       = '0;
    wp_chans     = '0;
    wp_rate      = '0;
    wp_align     = '0;
    wp_bits      = '0;
    wp_frame_pos = '0;
  endtask

  // Bytes of the fmt chunk that are kept: the smaller of its size and eighteen.
  function automatic logic [31:0] fmt_keep_len();
    return (wp_size < 32'd18) ? wp_size : 32'd18;
  endfunction

  // Check the stored fmt fields and move on to the rest of the chunk.
  task automatic fmt_close();
    logic [31:0] rest;
    if (wp_tag != TAG_PCM || wp_bits != BITS_PCM16 || wp_rate == '0 || wp_align == '0) begin
      wp_phase = PH_ERR_FMT;
      return;
    end
    wp_have_fmt = 1'b1;
    rest = wp_size - fmt_keep_len();
    wp_index = '0;
    if (rest == '0) begin
      wp_phase = PH_CHDR;
    end else begin
      wp_left  = {1'b0, rest};
      wp_phase = PH_SKIP;
    end
  endtask

  // A chunk header is complete: pick what to do with the body.
  task automatic chunk_start();
    logic [31:0] skip;
    wp_index = '0;
    if (wp_id == ID_FMT) begin
      if (fmt_keep_len() == '0) fmt_close();
      else wp_phase = PH_FMT;
    end else if (wp_id == ID_DATA) begin
      if (!wp_have_fmt) begin
        wp_phase = PH_ERR_ORD;
      end else begin
        wp_left      = {1'b0, wp_size};
        wp_frame_pos = '0;
        wp_phase     = (wp_left < wp_align) ? PH_DONE : PH_DATA;
      end
    end else begin
      // Unknown chunks are padded to even length, wrapping at 32 bits.
      skip = (wp_size + 32'd1) & SKIP_ALIGN_MASK;
      if (skip == '0) begin
        wp_phase = PH_CHDR;
      end else begin
        wp_left  = {1'b0, skip};
        wp_phase = PH_SKIP;
      end
    end
  endtask

  // Advance the tracked parser by one file byte and form the expected result beat.
  task automatic parse_byte(input wcp_in_t beat, output wcp_out_t r);
    logic [7:0] b;
    logic       audio;
    logic       fend;
    logic       last;
    logic [2:0] k3;
    logic [2:0] st;
    b     = beat.file_byte;
    audio = 1'b0;
    fend  = 1'b0;
    last  = 1'b0;
    if (beat.first_byte) parser_clear();
    case (wp_phase)
      PH_HEADER: begin
        if ((wp_index < 5'd4 || wp_index >= 5'd8) && wp_index < 5'd12 &&
            RIFF_WAVE_MAGIC[8*(11 - wp_index) +: 8] != b) begin
          wp_phase = PH_ERR_RIFF;
        end else begin
          wp_index = wp_index + 5'd1;
          if (wp_index >= 5'd12) begin
            wp_index = '0;
            wp_phase = PH_CHDR;
          end
        end
      end
      PH_CHDR: begin
        k3 = wp_index[2:0];
        if (k3 < 3'd4) begin
          wp_id = {wp_id[23:0], b};
          if (k3 == 3'd0) wp_size = '0;
        end else begin
          wp_size = wp_size | ({24'd0, b} << (8 * (k3 - 3'd4)));
        end
        wp_index = {2'b00, k3} + 5'd1;
        if (wp_index >= 5'd8) chunk_start();
      end
      PH_FMT: begin
        // Fields land byte by byte in the layout of the format header.
        if (wp_index == 5'd0) wp_tag[7:0] = b;
        else if (wp_index == 5'd1) wp_tag[15:8] = b;
        else if (wp_index == 5'd2) wp_chans[7:0] = b;
        else if (wp_index == 5'd3) wp_chans[15:8] = b;
        else if (wp_index < 5'd8) wp_rate[8*(wp_index - 4) +: 8] = b;
        else if (wp_index == 5'd12) wp_align[7:0] = b;
        else if (wp_index == 5'd13) wp_align[15:8] = b;
        else if (wp_index == 5'd14) wp_bits[7:0] = b;
        else if (wp_index == 5'd15) wp_bits[15:8] = b;
        wp_index = wp_index + 5'd1;
        if ({27'd0, wp_index} >= fmt_keep_len()) fmt_close();
      end
      PH_SKIP: begin
        if (wp_left != '0) wp_left = wp_left - 33'd1;
        if (wp_left == '0) begin
          wp_index = '0;
          wp_phase = PH_CHDR;
        end
      end
      PH_DATA: begin
        audio = 1'b1;
        if (wp_left != '0) wp_left = wp_left - 33'd1;
        wp_frame_pos = wp_frame_pos + 16'd1;
        if (wp_frame_pos >= wp_align) begin
          fend = 1'b1;
          wp_frame_pos = '0;
          if (wp_left < wp_align) begin
            last = 1'b1;
            wp_phase = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase
    // The final byte of a file that never reached its audio is an error.
    if (beat.end_of_file) begin
      if (wp_phase == PH_HEADER) wp_phase = PH_ERR_RIFF;
      else if (wp_phase == PH_CHDR || wp_phase == PH_FMT || wp_phase == PH_SKIP)
        wp_phase = PH_ERR_MISS;
    end
    if (audio) begin
      st = ST_AUDIO;
    end else begin
      case (wp_phase)
        PH_DONE:     st = ST_DONE;
        PH_ERR_RIFF: st = ST_BAD_RIFF;
        PH_ERR_FMT:  st = ST_BAD_FORMAT;
        PH_ERR_ORD:  st = ST_DATA_EARLY;
        PH_ERR_MISS: st = ST_MISSING;
        default:     st = ST_HEADER;
      endcase
    end
    r.status        = st;
    r.audio_byte    = audio ? b : 8'd0;
    r.frame_end     = fend;
    r.last_audio    = last;
    r.channel_count = wp_have_fmt ? wp_chans : 16'd0;
    r.sample_rate   = wp_have_fmt ? wp_rate : 32'd0;
    r.frame_bytes   = wp_have_fmt ? wp_align : 16'd0;
  endtask

  // File building helpers.
  task automatic put_id(input logic [31:0] id);
    for (int i = 3; i >= 0; i--) file_q.push_back(id[8*i +: 8]);
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
  endtask

  task automatic put_fill(input int n);
    repeat (n) file_q.push_back(8'($urandom));
  endtask

  function automatic logic [31:0] junk_id();
    logic [31:0] id;
    id = $urandom;
    if (id == ID_FMT || id == ID_DATA) id = id ^ 32'h1;
    return id;
  endfunction

  task automatic put_junk(input int size);
    put_id(junk_id());
    put_le(size, 4);
    put_fill((size + 1) & ~1);
  endtask

  function automatic logic [31:0] nonzero_rate();
    logic [31:0] r;
    r = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
    if (r == '0) r = 32'd1;
    return r;
  endfunction

  // A fmt chunk: the first eighteen bytes hold the format header, the rest is filler.
  task automatic put_fmt(input int size, input logic [15:0] tag, input logic [31:0] rate,
                         input logic [15:0] align, input logic [15:0] bits);
    logic [143:0] img;
    img = {16'($urandom), bits, align, 32'($urandom), rate, 16'($urandom), tag};
    put_id(ID_FMT);
    put_le(size, 4);
    for (int i = 0; i < size && i < 18; i++) file_q.push_back(img[8*i +: 8]);
    if (size > 18) put_fill(size - 18);
  endtask

  function automatic wav_shape_t pick_shape();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return WF_CLEAN;
    if (p < 50) return WF_TWO_FMT;
    if (p < 58) return WF_SHORT_DATA;
    if (p < 66) return WF_CUT_IN_DATA;
    if (p < 72) return WF_DATA_FIRST;
    if (p < 79) return WF_NO_DATA;
    if (p < 85) return WF_WRAP_SIZE;
    if (p < 91) return WF_BAD_FMT;
    if (p < 95) return WF_CUT_HEADER;
    return WF_NOISE;
  endfunction

  task automatic build_file(input wav_shape_t shape);
    logic [15:0] align;
    int          dsize;
    int          sent;
    int          keep;
    int          which;
    file_q.delete();
    if (shape == WF_NOISE) begin
      put_fill($urandom_range(1, 16));
      return;
    end
    put_id(TAG_RIFF);
    put_le($urandom, 4);
    put_id(TAG_WAVE);
    if (shape == WF_CUT_HEADER) begin
      keep = $urandom_range(1, 11);
      file_q = file_q[0:keep-1];
      return;
    end
    if ($urandom_range(0, 1) == 1) put_junk($urandom_range(0, 9));
    align = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom_range(1, 6));
    if (shape == WF_SHORT_DATA) align = 16'($urandom_range(2, 6));
    case (shape)
      WF_DATA_FIRST: begin
      end
      WF_BAD_FMT: begin
        // Break exactly one of the four checked fields; short sizes break it anyway.
        which = $urandom_range(0, 3);
        put_fmt(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(16, 24),
                (which == 0) ? 16'($urandom_range(2, 65535)) : TAG_PCM,
                (which == 2) ? 32'd0 : nonzero_rate(),
                (which == 3) ? 16'd0 : align,
                (which == 1) ? (($urandom_range(0, 1) == 1) ? 16'd8 : 16'd24) : BITS_PCM16);
      end
      WF_WRAP_SIZE: begin
        // A size of all ones pads to zero, so the chunk has no body.
        put_id(junk_id());
        put_le(32'hFFFF_FFFF, 4);
        put_fmt($urandom_range(16, 24), TAG_PCM, nonzero_rate(), align, BITS_PCM16);
      end
      WF_TWO_FMT: begin
        put_fmt($urandom_range(16, 24), TAG_PCM, nonzero_rate(),
                16'($urandom_range(1, 6)), BITS_PCM16);
        put_junk($urandom_range(0, 9));
        put_fmt($urandom_range(16, 24), TAG_PCM, nonzero_rate(), align, BITS_PCM16);
      end
      default: begin
        put_fmt($urandom_range(16, 24), TAG_PCM, nonzero_rate(), align, BITS_PCM16);
      end
    endcase
    if (shape == WF_NO_DATA) begin
      if ($urandom_range(0, 1) == 1) begin
        put_id(junk_id());
        put_le(32'hFFFF_FFFE, 4);
        put_fill($urandom_range(1, 5));
      end else begin
        put_junk($urandom_range(0, 9));
      end
      return;
    end
    if (shape == WF_SHORT_DATA) dsize = $urandom_range(0, align - 1);
    else if (shape == WF_CUT_IN_DATA) dsize = $urandom_range(4, 24);
    else dsize = $urandom_range(0, 16);
    if (shape == WF_CUT_IN_DATA) sent = $urandom_range(1, dsize - 1);
    else sent = dsize + $urandom_range(0, 3);
    put_id(ID_DATA);
    put_le(dsize, 4);
    put_fill(sent);
  endtask

  // Idle mix by progress: none, sender gaps, receiver stalls, then both.
  task automatic set_idle_mix(input int done);
    case (done * 4 / RANDOM_ITEMS)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 53; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 53; end
      default: begin send_gap_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  // Offer one input beat, wait for it to be taken, then queue what it should produce.
  task automatic offer_byte(input wcp_in_t beat, input logic typed, input logic [2:0] st);
    wcp_out_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_beat  <= beat;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    parse_byte(beat, predicted);
    if (typed) begin
      predicted = '0;
      predicted.status = st;
    end
    pending_results.push_back(predicted);
  endtask

  task automatic check_result(input wcp_out_t got);
    wcp_out_t want;
    if (pending_results.size() == 0) begin
      bad_beats++;
      if (bad_beats <= 10)
        $display("Unexpected result beat: status %0d audio %h", got.status, got.audio_byte);
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status || got.audio_byte !== want.audio_byte ||
          got.frame_end !== want.frame_end || got.last_audio !== want.last_audio ||
          got.channel_count !== want.channel_count || got.sample_rate !== want.sample_rate ||
          got.frame_bytes !== want.frame_bytes) begin
        bad_beats++;
        if (bad_beats <= 10) begin
          $display("Mismatch: exp st=%0d b=%h fe=%b la=%b ch=%h sr=%h fb=%h",
                   want.status, want.audio_byte, want.frame_end, want.last_audio,
                   want.channel_count, want.sample_rate, want.frame_bytes);
          $display("          got st=%0d b=%h fe=%b la=%b ch=%h sr=%h fb=%h",
                   got.status, got.audio_byte, got.frame_end, got.last_audio,
                   got.channel_count, got.sample_rate, got.frame_bytes);
        end
      end
    end
  endtask

  // Result side: check each accepted beat, then decide ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) check_result(result_beat);
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (hold_asked && !hold_done) begin
      // One long hold-off so the block fills up and stalls its input.
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Give up when no beat moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    wcp_in_t    beat;
    wav_shape_t shape;
    int         random_sent;
    int         files;
    logic       with_first;
    logic       with_eof;
    int         last;
    parser_clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (directed_rows[i]) begin
      beat.file_byte   = directed_rows[i].b;
      beat.first_byte  = directed_rows[i].sof;
      beat.end_of_file = directed_rows[i].eof;
      offer_byte(beat, directed_rows[i].typed, directed_rows[i].status);
    end

    // Random files: one of each kind first, then a weighted mix.
    random_sent = 0;
    files = 0;
    while (random_sent < RANDOM_ITEMS) begin
      shape = (files < NUM_SHAPES) ? wav_shape_t'(files) : pick_shape();
      build_file(shape);
      with_first = ($urandom_range(0, 9) != 0);
      with_eof   = ($urandom_range(0, 7) != 0);
      last = file_q.size() - 1;
      for (int i = 0; i <= last; i++) begin
        set_idle_mix(random_sent);
        if (random_sent >= 40) hold_asked = 1'b1;
        beat.file_byte = file_q[i];
        if (shape == WF_NOISE) begin
          beat.first_byte  = ($urandom_range(0, 7) == 0);
          beat.end_of_file = ($urandom_range(0, 7) == 0);
        end else begin
          beat.first_byte  = (i == 0) && with_first;
          beat.end_of_file = (i == last) && with_eof;
        end
        offer_byte(beat, 1'b0, ST_HEADER);
        random_sent++;
      end
      files++;
    end
    item_valid <= 1'b0;
    send_gap_pct = 0;
    recv_stall_pct = 0;

    // Drain, then watch for any stray beat.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_beats == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
